// ===== hw/rtl/scsm_pkg.sv =====
package scsm_pkg;

  // Widths that hold an '=' run or a result count for any bracket depth up to 62
  localparam int LVL_W = 6;
  localparam int TOT_W = 7;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_LBR   = 8'd91;
  localparam logic [7:0] CH_BSL   = 8'd92;
  localparam logic [7:0] CH_RBR   = 8'd93;
  localparam logic [7:0] CH_BTICK = 8'd96;

  localparam logic [1:0] Q_SQ    = 2'd1;
  localparam logic [1:0] Q_DQ    = 2'd2;
  localparam logic [1:0] Q_BTICK = 2'd3;

  typedef enum logic [2:0] {
    M_CODE    = 3'd0,
    M_LINE    = 3'd1,
    M_DASH    = 3'd2,
    M_DASH_EQ = 3'd3,
    M_LONG    = 3'd4,
    M_BLOCK   = 3'd5,
    M_QOPEN   = 3'd6,
    M_STRING  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    P_NONE    = 2'd0,
    P_SLASH   = 2'd1,
    P_DASH    = 2'd2,
    P_BRACKET = 2'd3
  } pend_t;

  // One input byte's worth of output: held group, current byte, trailing group
  typedef struct packed {
    pend_t             a_kind;
    logic [LVL_W-1:0]  a_cnt;
    logic              a_mask;
    logic [7:0]        c_byte;
    pend_t             b_kind;
    logic [LVL_W-1:0]  b_cnt;
    logic              last;
    logic [TOT_W-1:0]  n_a;
    logic [TOT_W-1:0]  n_ac;
    logic [TOT_W-1:0]  total;
  } cmd_t;

endpackage

// ===== hw/rtl/scsm_front.sv =====
module scsm_front import scsm_pkg::*; #(
  parameter int MAX_LEVEL = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam int LvlW = $clog2(MAX_LEVEL + 1);
  localparam logic [LvlW-1:0] MaxLvl = LvlW'(MAX_LEVEL);

  mode_t           mode, mode_next;
  pend_t           pk, pk_next;
  logic [LvlW-1:0] peq, peq_next;
  logic [LvlW-1:0] lvl, lvl_next;
  logic [LvlW-1:0] ceq, ceq_next;
  logic            cs, cs_next;
  logic [1:0]      qc, qc_next;
  logic [1:0]      qrun, qrun_next;
  logic            trip, trip_next;
  logic            esc, esc_next;
  logic            star, star_next;

  logic            accept;
  logic            go_plain, go_string;
  logic [7:0]      qb;
  logic            plain_out;
  pend_t           a_kind, b_kind;
  logic [LvlW-1:0] a_cnt, b_cnt;
  logic            a_mask, c_on, c_msk;
  logic [TOT_W-1:0] n_a, n_ac, n_b;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    unique case (qc)
      Q_SQ:    qb = CH_SQ;
      Q_DQ:    qb = CH_DQ;
      default: qb = CH_BTICK;
    endcase
  end

  always_comb begin : next_state
    mode_next = mode;
    pk_next   = pk;
    peq_next  = peq;
    lvl_next  = lvl;
    ceq_next  = ceq;
    cs_next   = cs;
    qc_next   = qc;
    qrun_next = qrun;
    trip_next = trip;
    esc_next  = esc;
    star_next = star;
    go_plain  = 1'b0;
    go_string = 1'b0;
    unique case (mode)
      M_CODE: begin
        unique case (pk)
          P_SLASH: begin
            pk_next = P_NONE;
            if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
              mode_next = (in_byte == CH_SLASH) ? M_LINE : M_BLOCK;
              star_next = 1'b0;
            end else begin
              go_plain = 1'b1;
            end
          end
          P_DASH: begin
            pk_next = P_NONE;
            if (in_byte == CH_DASH) mode_next = M_DASH;
            else go_plain = 1'b1;
          end
          P_BRACKET: begin
            if (in_byte == CH_EQ && peq < MaxLvl) begin
              peq_next = peq + LvlW'(1);
            end else begin
              pk_next  = P_NONE;
              peq_next = '0;
              if (in_byte == CH_LBR) begin
                mode_next = M_LONG;
                lvl_next  = peq;
                cs_next   = 1'b0;
                ceq_next  = '0;
              end else if (in_byte != CH_EQ) begin
                go_plain = 1'b1;
              end
            end
          end
          default: go_plain = 1'b1;
        endcase
      end
      M_LINE: begin
        if (in_byte == CH_LF) mode_next = M_CODE;
      end
      M_DASH: begin
        if (in_byte == CH_LBR) begin
          mode_next = M_DASH_EQ;
          peq_next  = '0;
        end else begin
          mode_next = (in_byte == CH_LF) ? M_CODE : M_LINE;
        end
      end
      M_DASH_EQ: begin
        if (in_byte == CH_EQ) begin
          if (peq < MaxLvl) peq_next = peq + LvlW'(1);
          else mode_next = M_LINE;
        end else if (in_byte == CH_LBR) begin
          mode_next = M_LONG;
          lvl_next  = peq;
          cs_next   = 1'b0;
          ceq_next  = '0;
        end else begin
          mode_next = (in_byte == CH_LF) ? M_CODE : M_LINE;
        end
        if (mode_next != M_DASH_EQ) peq_next = '0;
      end
      M_LONG: begin
        if (!cs) begin
          if (in_byte == CH_RBR) begin
            cs_next  = 1'b1;
            ceq_next = '0;
          end
        end else if (in_byte == CH_EQ) begin
          if (ceq < lvl) ceq_next = ceq + LvlW'(1);
          else cs_next = 1'b0;
        end else if (in_byte == CH_RBR) begin
          if (ceq == lvl) mode_next = M_CODE;
          ceq_next = '0;
        end else begin
          cs_next = 1'b0;
        end
      end
      M_BLOCK: begin
        if (star && in_byte == CH_SLASH) mode_next = M_CODE;
        else star_next = (in_byte == CH_STAR);
      end
      M_QOPEN: begin
        if (qrun >= 2'd2) begin
          qrun_next = '0;
          if (in_byte == qb) begin
            mode_next = M_STRING;
            trip_next = 1'b1;
          end else begin
            mode_next = M_CODE;
            go_plain  = 1'b1;
          end
        end else if (in_byte == qb) begin
          qrun_next = 2'd2;
        end else begin
          mode_next = M_STRING;
          qrun_next = '0;
          go_string = 1'b1;
        end
      end
      default: go_string = 1'b1;
    endcase

    if (go_string) begin
      if (esc) begin
        esc_next  = 1'b0;
        qrun_next = '0;
      end else if (in_byte == CH_BSL) begin
        esc_next  = 1'b1;
        qrun_next = '0;
      end else if (trip) begin
        if (in_byte == qb) begin
          if (qrun_next >= 2'd2) mode_next = M_CODE;
          qrun_next = qrun_next + 2'd1;
        end else begin
          qrun_next = '0;
        end
      end else if (in_byte == qb) begin
        mode_next = M_CODE;
      end
    end

    if (go_plain) begin
      unique case (in_byte) inside
        CH_HASH:  mode_next = M_LINE;
        CH_SLASH: pk_next = P_SLASH;
        CH_DASH:  pk_next = P_DASH;
        CH_LBR: begin
          pk_next  = P_BRACKET;
          peq_next = '0;
        end
        CH_SQ, CH_DQ, CH_BTICK: begin
          qc_next   = (in_byte == CH_SQ) ? Q_SQ : (in_byte == CH_DQ) ? Q_DQ : Q_BTICK;
          mode_next = (in_byte == CH_BTICK) ? M_STRING : M_QOPEN;
          qrun_next = (in_byte == CH_BTICK) ? 2'd0 : 2'd1;
          trip_next = 1'b0;
          esc_next  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin : outputs
    a_kind    = P_NONE;
    a_cnt     = '0;
    a_mask    = 1'b0;
    c_on      = 1'b0;
    c_msk     = 1'b0;
    plain_out = 1'b0;
    unique case (mode)
      M_CODE: begin
        unique case (pk)
          P_SLASH: begin
            a_kind = P_SLASH;
            if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
              a_mask = 1'b1;
              c_on   = 1'b1;
              c_msk  = 1'b1;
            end else begin
              plain_out = 1'b1;
            end
          end
          P_DASH: begin
            a_kind = P_DASH;
            if (in_byte == CH_DASH) begin
              a_mask = 1'b1;
              c_on   = 1'b1;
              c_msk  = 1'b1;
            end else begin
              plain_out = 1'b1;
            end
          end
          P_BRACKET: begin
            if (in_byte == CH_EQ) begin
              if (peq >= MaxLvl) begin
                a_kind = P_BRACKET;
                a_cnt  = peq;
                c_on   = 1'b1;
              end
            end else begin
              a_kind = P_BRACKET;
              a_cnt  = peq;
              if (in_byte == CH_LBR) begin
                a_mask = 1'b1;
                c_on   = 1'b1;
                c_msk  = 1'b1;
              end else begin
                plain_out = 1'b1;
              end
            end
          end
          default: plain_out = 1'b1;
        endcase
      end
      M_QOPEN: begin
        if (qrun >= 2'd2 && in_byte != qb) begin
          plain_out = 1'b1;
        end else begin
          c_on  = 1'b1;
          c_msk = 1'b1;
        end
      end
      default: begin
        c_on  = 1'b1;
        c_msk = 1'b1;
      end
    endcase

    if (plain_out) begin
      unique case (in_byte) inside
        CH_SLASH, CH_DASH, CH_LBR: ;
        CH_HASH, CH_SQ, CH_DQ, CH_BTICK: begin
          c_on  = 1'b1;
          c_msk = 1'b1;
        end
        default: c_on = 1'b1;
      endcase
    end

    b_kind = in_last ? pk_next : P_NONE;
    b_cnt  = (b_kind == P_BRACKET) ? peq_next : '0;
  end

  always_comb begin
    n_a  = (a_kind != P_NONE) ? TOT_W'(a_cnt) + TOT_W'(1) : '0;
    n_ac = n_a + TOT_W'(c_on);
    n_b  = (b_kind != P_NONE) ? TOT_W'(b_cnt) + TOT_W'(1) : '0;
    push_cmd.a_kind = a_kind;
    push_cmd.a_cnt  = LVL_W'(a_cnt);
    push_cmd.a_mask = a_mask;
    push_cmd.c_byte = (c_msk && in_byte != CH_CR && in_byte != CH_LF) ? CH_SP : in_byte;
    push_cmd.b_kind = b_kind;
    push_cmd.b_cnt  = LVL_W'(b_cnt);
    push_cmd.last   = in_last;
    push_cmd.n_a    = n_a;
    push_cmd.n_ac   = n_ac;
    push_cmd.total  = n_ac + n_b;
  end

  assign push = accept && (push_cmd.total != '0);

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      mode <= M_CODE;
      pk   <= P_NONE;
      peq  <= '0;
      lvl  <= '0;
      ceq  <= '0;
      cs   <= 1'b0;
      qc   <= '0;
      qrun <= '0;
      trip <= 1'b0;
      esc  <= 1'b0;
      star <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      pk   <= pk_next;
      peq  <= peq_next;
      lvl  <= lvl_next;
      ceq  <= ceq_next;
      cs   <= cs_next;
      qc   <= qc_next;
      qrun <= qrun_next;
      trip <= trip_next;
      esc  <= esc_next;
      star <= star_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_last) |=> (mode == M_CODE && pk == P_NONE))
    else $error("scanner not back in code after last byte");

  a_eq_bounded: assert property (@(posedge clk) disable iff (rst)
    (peq <= MaxLvl) && (ceq <= lvl))
    else $error("bracket level count out of range");

endmodule

// ===== hw/rtl/scsm_queue.sv =====
module scsm_queue import scsm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            slot [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("transaction pushed into full queue");

endmodule

// ===== hw/rtl/scsm_back.sv =====
module scsm_back import scsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_last
);

  logic [TOT_W-1:0] pos;
  logic             advance;
  logic             at_end;
  logic [7:0]       gen_byte;

  function automatic logic [7:0] kind_char(pend_t k);
    unique case (k)
      P_SLASH:   return CH_SLASH;
      P_DASH:    return CH_DASH;
      default:   return CH_LBR;
    endcase
  endfunction

  assign advance = head_valid && (!out_valid || !out_stall);
  assign at_end  = (pos == head.total - TOT_W'(1));
  assign pop     = advance && at_end;

  always_comb begin
    if (pos < head.n_a) begin
      gen_byte = (pos == '0) ? kind_char(head.a_kind) : CH_EQ;
      if (head.a_mask) gen_byte = CH_SP;
    end else if (pos < head.n_ac) begin
      gen_byte = head.c_byte;
    end else begin
      gen_byte = (pos == head.n_ac) ? kind_char(head.b_kind) : CH_EQ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      pos       <= at_end ? '0 : pos + TOT_W'(1);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= gen_byte;
      run_last    <= at_end;
      stream_last <= at_end && head.last;
    end
  end

  a_pos_in_cmd: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.total != '0 && pos < head.total))
    else $error("expansion position outside transaction");

  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_last) |-> run_last)
    else $error("stream end not on run end");

  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (pos == '0))
    else $error("position left mid-transaction with queue empty");

endmodule

// ===== hw/rtl/source_comment_string_masker.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_byte, in_last
// out     | output    | out_valid/out_stall | out_byte, run_last, stream_last
//
// One byte per cycle when queued and unstalled; an input byte's N results go in order.
// An accepted byte passes the queue register, then the output register, before out_valid.
// The command queue (QUEUE_DEPTH entries) lets input run on while expansions drain.
// in_stall rises only when the queue is full; out_stall freezes the output register while out_valid is high.
// rst empties the queue and returns the scanner to code mode.
module source_comment_string_masker import scsm_pkg::*; #(
  parameter int MAX_LEVEL   = 14,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_last
);

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_push_cmd, q_head;

  scsm_front #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .full     (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  scsm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  scsm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_last (stream_last)
  );

endmodule

// ===== tb/sv/masker_checker.sv =====
module masker_checker import scsm_pkg::*; #(
  parameter int MAX_LEVEL = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       stream_last,
  output int         failures,
  output int         pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       text_end;
  } masked_t;

  mode_t            scan;
  pend_t            held;
  logic [LVL_W-1:0] held_eqs;
  logic [LVL_W-1:0] lvl;
  logic [LVL_W-1:0] close_eqs;
  logic             close_open;
  logic [1:0]       qsel;
  logic [1:0]       qrun;
  logic             triple;
  logic             esc;
  logic             star;

  logic [7:0]       run_q[$];
  masked_t          masked_q[$];
  masked_t          want;
  int               errs = 0;

  function automatic void clear_scanner();
    scan = M_CODE;
    held = P_NONE;
    held_eqs = '0;
    lvl = '0;
    close_eqs = '0;
    close_open = 1'b0;
    qsel = '0;
    qrun = '0;
    triple = 1'b0;
    esc = 1'b0;
    star = 1'b0;
  endfunction

  function automatic void append_out(input logic [7:0] b, input logic masked);
    if (masked && b != CH_CR && b != CH_LF) begin
      run_q = {run_q, CH_SP};
    end else begin
      run_q = {run_q, b};
    end
  endfunction

  function automatic logic [7:0] quote_ch();
    case (qsel)
      Q_SQ: return CH_SQ;
      Q_DQ: return CH_DQ;
      default: return CH_BTICK;
    endcase
  endfunction

  function automatic void flush_held(input logic masked);
    case (held)
      P_SLASH: append_out(CH_SLASH, masked);
      P_DASH: append_out(CH_DASH, masked);
      P_BRACKET: begin
        append_out(CH_LBR, masked);
        for (int i = 0; i < held_eqs; i++) append_out(CH_EQ, masked);
      end
      default: ;
    endcase
    held = P_NONE;
    held_eqs = '0;
  endfunction

  function automatic void open_long(input logic [LVL_W-1:0] level);
    scan = M_LONG;
    lvl = level;
    close_open = 1'b0;
    close_eqs = '0;
  endfunction

  function automatic void scan_plain(input logic [7:0] b);
    case (b)
      CH_HASH: begin
        scan = M_LINE;
        append_out(b, 1'b1);
      end
      CH_SLASH: held = P_SLASH;
      CH_DASH: held = P_DASH;
      CH_LBR: begin
        held = P_BRACKET;
        held_eqs = '0;
      end
      CH_SQ, CH_DQ, CH_BTICK: begin
        qsel = (b == CH_SQ) ? Q_SQ : (b == CH_DQ) ? Q_DQ : Q_BTICK;
        if (b == CH_BTICK) begin
          scan = M_STRING;
          qrun = 2'd0;
        end else begin
          scan = M_QOPEN;
          qrun = 2'd1;
        end
        triple = 1'b0;
        esc = 1'b0;
        append_out(b, 1'b1);
      end
      default: append_out(b, 1'b0);
    endcase
  endfunction

  function automatic void scan_code(input logic [7:0] b);
    logic [LVL_W-1:0] level;
    if (held == P_SLASH) begin
      if (b == CH_SLASH || b == CH_STAR) begin
        flush_held(1'b1);
        append_out(b, 1'b1);
        if (b == CH_SLASH) scan = M_LINE;
        else scan = M_BLOCK;
        star = 1'b0;
        return;
      end
      flush_held(1'b0);
    end else if (held == P_DASH) begin
      if (b == CH_DASH) begin
        flush_held(1'b1);
        append_out(b, 1'b1);
        scan = M_DASH;
        return;
      end
      flush_held(1'b0);
    end else if (held == P_BRACKET) begin
      if (b == CH_EQ) begin
        if (held_eqs < MAX_LEVEL) begin
          held_eqs++;
        end else begin
          flush_held(1'b0);
          append_out(b, 1'b0);
        end
        return;
      end
      if (b == CH_LBR) begin
        level = held_eqs;
        flush_held(1'b1);
        append_out(b, 1'b1);
        open_long(level);
        return;
      end
      flush_held(1'b0);
    end
    scan_plain(b);
  endfunction

  function automatic void scan_string(input logic [7:0] b);
    append_out(b, 1'b1);
    if (esc) begin
      esc = 1'b0;
      qrun = 2'd0;
    end else if (b == CH_BSL) begin
      esc = 1'b1;
      qrun = 2'd0;
    end else if (triple) begin
      if (b == quote_ch()) begin
        qrun++;
        if (qrun >= 2'd3) scan = M_CODE;
      end else begin
        qrun = 2'd0;
      end
    end else if (b == quote_ch()) begin
      scan = M_CODE;
    end
  endfunction

  function automatic void scan_long(input logic [7:0] b);
    append_out(b, 1'b1);
    if (!close_open) begin
      if (b == CH_RBR) begin
        close_open = 1'b1;
        close_eqs = '0;
      end
    end else if (b == CH_EQ) begin
      if (close_eqs < lvl) close_eqs++;
      else close_open = 1'b0;
    end else if (b == CH_RBR) begin
      if (close_eqs == lvl) scan = M_CODE;
      close_eqs = '0;
    end else begin
      close_open = 1'b0;
    end
  endfunction

  function automatic void mask_byte(input logic [7:0] b, input logic last);
    masked_t r;
    run_q.delete();
    case (scan)
      M_CODE: scan_code(b);
      M_LINE: begin
        append_out(b, 1'b1);
        if (b == CH_LF) scan = M_CODE;
      end
      M_DASH: begin
        append_out(b, 1'b1);
        if (b == CH_LBR) begin
          scan = M_DASH_EQ;
          held_eqs = '0;
        end else if (b == CH_LF) begin
          scan = M_CODE;
        end else begin
          scan = M_LINE;
        end
      end
      M_DASH_EQ: begin
        append_out(b, 1'b1);
        if (b == CH_EQ) begin
          if (held_eqs < MAX_LEVEL) held_eqs++;
          else scan = M_LINE;
        end else if (b == CH_LBR) begin
          open_long(held_eqs);
        end else if (b == CH_LF) begin
          scan = M_CODE;
        end else begin
          scan = M_LINE;
        end
        if (scan != M_DASH_EQ) held_eqs = '0;
      end
      M_LONG: scan_long(b);
      M_BLOCK: begin
        append_out(b, 1'b1);
        if (star && b == CH_SLASH) scan = M_CODE;
        else star = (b == CH_STAR);
      end
      M_QOPEN: begin
        if (qrun >= 2'd2) begin
          if (b == quote_ch()) begin
            append_out(b, 1'b1);
            scan = M_STRING;
            triple = 1'b1;
            qrun = 2'd0;
          end else begin
            scan = M_CODE;
            qrun = 2'd0;
            scan_plain(b);
          end
        end else if (b == quote_ch()) begin
          append_out(b, 1'b1);
          qrun = 2'd2;
        end else begin
          scan = M_STRING;
          qrun = 2'd0;
          scan_string(b);
        end
      end
      default: scan_string(b);
    endcase
    if (last) begin
      flush_held(1'b0);
      clear_scanner();
    end
    for (int i = 0; i < run_q.size(); i++) begin
      r.ch = run_q[i];
      r.run_end = (i == run_q.size() - 1);
      r.text_end = last && (i == run_q.size() - 1);
      masked_q = {masked_q, r};
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scanner();
      masked_q.delete();
    end else begin
      if (in_valid && !in_stall) mask_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (masked_q.size() == 0) begin
          $error("out_byte: no result expected, got %0d", out_byte);
          errs++;
        end else begin
          want = masked_q.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte: expected %0d, got %0d", want.ch, out_byte);
            errs++;
          end
          if (run_last !== want.run_end) begin
            $error("run_last: expected %0d, got %0d", want.run_end, run_last);
            errs++;
          end
          if (stream_last !== want.text_end) begin
            $error("stream_last: expected %0d, got %0d", want.text_end, stream_last);
            errs++;
          end
        end
      end
    end
    pending <= masked_q.size();
    failures <= errs;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import scsm_pkg::*;

  localparam int MAX_LEVEL = 14;
  localparam int RANDOM_ITEMS = 260;
  localparam int LIMIT = 200000;

  typedef enum {
    SN_CODE, SN_LINE, SN_BLOCK, SN_LONG, SN_DASH_LONG,
    SN_STRING, SN_TRIPLE, SN_EMPTY, SN_HELD
  } snippet_t;

  typedef enum {ST_FLOW, ST_COIN, ST_TOGGLE, ST_SPARSE, ST_HOLD} stall_style_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;
  int         failures;
  int         pending;

  logic [7:0] text_q[$];
  int         burst_left = 0;
  int         items_sent = 0;
  int         cycle_count = 0;

  source_comment_string_masker #(.MAX_LEVEL(MAX_LEVEL)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .stream_last(stream_last)
  );

  masker_checker #(.MAX_LEVEL(MAX_LEVEL)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .stream_last(stream_last),
    .failures(failures), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0: return CH_HASH;
      1: return CH_SLASH;
      2: return CH_STAR;
      3: return CH_DASH;
      4: return CH_LBR;
      5: return CH_RBR;
      6: return CH_EQ;
      7: return CH_SQ;
      8: return CH_DQ;
      9: return CH_BTICK;
      10: return CH_BSL;
      11: return CH_LF;
      12: return CH_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_quote(input logic with_btick);
    case ($urandom_range(0, with_btick ? 2 : 1))
      0: return CH_SQ;
      1: return CH_DQ;
      default: return CH_BTICK;
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_filler(input int n);
    repeat (n) add_byte(pick_char());
  endfunction

  function automatic void add_long(input logic dashed);
    int eqs;
    eqs = ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_LEVEL + 1) : $urandom_range(0, 3);
    if (dashed) add_str("--");
    add_byte(CH_LBR);
    repeat (eqs) add_byte(CH_EQ);
    add_byte(CH_LBR);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_RBR);
        repeat ($urandom_range(0, eqs + 1)) add_byte(CH_EQ);
        if ($urandom_range(0, 1) == 1) add_byte(CH_RBR);
      end else begin
        add_byte(pick_char());
      end
    end
    add_byte(CH_RBR);
    repeat (eqs) add_byte(CH_EQ);
    add_byte(CH_RBR);
  endfunction

  function automatic void add_snippet();
    logic [7:0] q;
    snippet_t kind;
    kind = snippet_t'($urandom_range(0, 8));
    case (kind)
      SN_CODE: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      SN_LINE: begin
        case ($urandom_range(0, 2))
          0: add_byte(CH_HASH);
          1: add_str("//");
          default: add_str("--");
        endcase
        add_filler($urandom_range(0, 5));
        add_byte(CH_LF);
      end
      SN_BLOCK: begin
        add_str("/*");
        add_filler($urandom_range(0, 6));
        add_str("*/");
      end
      SN_LONG: add_long(1'b0);
      SN_DASH_LONG: add_long(1'b1);
      SN_STRING: begin
        q = pick_quote(1'b1);
        add_byte(q);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) add_byte(CH_BSL);
          add_byte(($urandom_range(0, 4) == 0) ? q : pick_char());
        end
        add_byte(q);
      end
      SN_TRIPLE: begin
        q = pick_quote(1'b0);
        repeat (3) add_byte(q);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 3))
            0: add_byte(q);
            1: begin
              add_byte(q);
              add_byte(q);
            end
            2: begin
              add_byte(CH_BSL);
              add_byte(q);
            end
            default: add_byte(pick_char());
          endcase
        end
        repeat (3) add_byte(q);
      end
      SN_EMPTY: begin
        q = pick_quote(1'b0);
        add_byte(q);
        add_byte(q);
        add_byte(pick_char());
      end
      default: begin
        case ($urandom_range(0, 2))
          0: add_byte(CH_SLASH);
          1: add_byte(CH_DASH);
          default: begin
            add_byte(CH_LBR);
            repeat ($urandom_range(0, 3)) add_byte(CH_EQ);
          end
        endcase
        add_byte(pick_char());
      end
    endcase
  endfunction

  task automatic offer(input logic [7:0] b, input logic l);
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(0, 12);
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      offer(text_q[i], i == text_q.size() - 1);
      items_sent++;
      pace();
    end
    text_q.delete();
  endtask

  initial begin
    int keep;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_byte(8'h00);
    add_str("/x-y[=z#c\n");
    add_byte(8'hFF);
    send_text();
    add_str("''x'\\''");
    send_text();
    add_str("a-");
    send_text();
    add_str("/*q");
    send_text();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 5)) add_snippet();
      // cut short to leave a construct open at the last byte
      if ($urandom_range(0, 5) == 0) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) text_q.delete(text_q.size() - 1);
      end
      send_text();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int span;
    int rx_cycles;
    bit held_off;
    stall_style_t style;
    out_stall = 1'b0;
    rx_cycles = 0;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      span = $urandom_range(4, 40);
      style = stall_style_t'($urandom_range(0, 3));
      // hold off long enough for the queue to fill and stall the input
      if (!held_off && rx_cycles >= 250) begin
        style = ST_HOLD;
        span = 120;
        held_off = 1'b1;
      end
      repeat (span) begin
        @(posedge clk);
        rx_cycles++;
        case (style)
          ST_FLOW: out_stall <= 1'b0;
          ST_COIN: out_stall <= ($urandom_range(0, 1) == 1);
          ST_TOGGLE: out_stall <= ~out_stall;
          ST_SPARSE: out_stall <= ($urandom_range(0, 4) == 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

endmodule
